// ----- rtl/wpm_pkg.sv -----
// Shared types, constants and helpers for the wildcard pattern matcher.
// Depends on nothing; every other RTL file imports it.
package wpm_pkg;

  localparam int PATTERN_DEPTH = 64;
  localparam int ADDR_W        = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int LEN_W         = $clog2(PATTERN_DEPTH + 1);

  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_AW       = $clog2(CMDQ_DEPTH);

  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QUESTION = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

  // Decoded command; subject bytes are already case-folded.
  typedef struct packed {
    opcode_t    op;
    logic [7:0] ch;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

// ----- rtl/wpm_front.sv -----
// Front end: accepts input items, decodes them into commands and queues them.
// Depends on wpm_pkg.
module wpm_front import wpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  in_item_t  item,
  output logic      full,
  output cmd_slot_t head,
  input  logic      take
);

  cmd_t               q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_AW:0]   count;
  logic               accept;
  logic               deq;
  cmd_t               cmd_in;

  assign full       = (count == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign accept     = push && !full;
  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];
  assign deq        = take && head.valid;

  always_comb begin
    cmd_in.op = opcode_t'(item.opcode);
    // fold subject bytes here so the engine compares against one side only
    cmd_in.ch = (cmd_in.op == OP_SUBJECT) ? fold(item.char_code) : item.char_code;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + 1'b1;
      if (deq)    rd_ptr <= rd_ptr + 1'b1;
      unique case ({accept, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/wpm_engine.sv -----
// Back end: pattern store, match sequencer and result queue.
// Depends on wpm_pkg; takes commands from wpm_front.
module wpm_engine import wpm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_slot_t head,
  output logic      take,
  output logic      empty,
  output result_t   result,
  input  logic      pop
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [LEN_W-1:0]  len, len_next;
  logic [LEN_W-1:0]  ptr, ptr_next;
  logic              star_seen, star_seen_next;
  logic [ADDR_W-1:0] star_pos, star_pos_next;
  logic              failed, failed_next;
  logic              ovf, ovf_next;
  cmd_t              cur;

  logic [7:0]        mem [PATTERN_DEPTH];
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] raddr;
  logic              mem_we;

  result_t           rq [2];
  logic              rq_wr, rq_rd;
  logic [1:0]        rq_cnt;
  logic              rq_full;
  logic              res_push;
  logic              res_matched;
  logic              res_pop;

  logic [LEN_W-1:0]  ptr_inc;
  logic [LEN_W-1:0]  ptr_back;
  logic              char_ok;

  assign rq_full  = (rq_cnt == 2'd2);
  assign empty    = (rq_cnt == 2'd0);
  assign result   = rq[rq_rd];
  assign res_pop  = pop && !empty;

  assign take     = (state == S_IDLE) && head.valid && !rq_full;
  assign ptr_inc  = ptr + 1'b1;
  assign ptr_back = LEN_W'(star_pos) + 1'b1;
  assign char_ok  = (rdata == CH_QUESTION) || (fold(rdata) == cur.ch);

  always_comb begin
    state_next     = state;
    len_next       = len;
    ptr_next       = ptr;
    star_seen_next = star_seen;
    star_pos_next  = star_pos;
    failed_next    = failed;
    ovf_next       = ovf;
    mem_we         = 1'b0;
    raddr          = ptr[ADDR_W-1:0];
    res_push       = 1'b0;
    res_matched    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (head.cmd.op)
            OP_CLEAR: begin
              len_next       = '0;
              ovf_next       = 1'b0;
              ptr_next       = '0;
              star_seen_next = 1'b0;
              star_pos_next  = '0;
              failed_next    = 1'b0;
            end
            OP_APPEND: begin
              if (len < LEN_W'(PATTERN_DEPTH)) begin
                mem_we   = 1'b1;
                len_next = len + 1'b1;
              end else begin
                ovf_next = 1'b1;
              end
            end
            OP_SUBJECT: begin
              if (!failed) begin
                if (ptr < len) begin
                  state_next = S_EVAL;
                end else if (star_seen) begin
                  ptr_next = ptr_back;
                end else begin
                  failed_next = 1'b1;
                end
              end
            end
            OP_END: begin
              if (!failed && ptr < len) begin
                state_next = S_EVAL;
              end else begin
                res_push       = 1'b1;
                res_matched    = !failed;
                ptr_next       = '0;
                star_seen_next = 1'b0;
                star_pos_next  = '0;
                failed_next    = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end

      S_EVAL: begin
        if (rdata == CH_STAR) begin
          // skip the star, remember it and read the next pattern byte
          star_seen_next = 1'b1;
          star_pos_next  = ptr[ADDR_W-1:0];
          ptr_next       = ptr_inc;
          raddr          = ptr_inc[ADDR_W-1:0];
          if (ptr_inc >= len) begin
            // pattern ends in a star: subject byte falls back onto the same spot
            state_next = S_IDLE;
            if (cur.op == OP_END) begin
              res_push       = 1'b1;
              res_matched    = 1'b1;
              ptr_next       = '0;
              star_seen_next = 1'b0;
              star_pos_next  = '0;
              failed_next    = 1'b0;
            end
          end
        end else begin
          state_next = S_IDLE;
          if (cur.op == OP_END) begin
            // a non-star byte is left, so the pattern is not exhausted
            res_push       = 1'b1;
            res_matched    = 1'b0;
            ptr_next       = '0;
            star_seen_next = 1'b0;
            star_pos_next  = '0;
            failed_next    = 1'b0;
          end else if (char_ok) begin
            ptr_next = ptr_inc;
          end else if (star_seen) begin
            ptr_next = ptr_back;
          end else begin
            failed_next = 1'b1;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[len[ADDR_W-1:0]] <= head.cmd.ch;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= head.cmd;
    end
    if (res_push) begin
      rq[rq_wr] <= '{matched: res_matched, pattern_overflow: ovf};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      ptr       <= '0;
      star_seen <= 1'b0;
      star_pos  <= '0;
      failed    <= 1'b0;
      ovf       <= 1'b0;
      rq_wr     <= 1'b0;
      rq_rd     <= 1'b0;
      rq_cnt    <= '0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      ptr       <= ptr_next;
      star_seen <= star_seen_next;
      star_pos  <= star_pos_next;
      failed    <= failed_next;
      ovf       <= ovf_next;
      if (res_push) rq_wr <= ~rq_wr;
      if (res_pop)  rq_rd <= ~rq_rd;
      unique case ({res_push, res_pop})
        2'b10:   rq_cnt <= rq_cnt + 1'b1;
        2'b01:   rq_cnt <= rq_cnt - 1'b1;
        default: rq_cnt <= rq_cnt;
      endcase
    end
  end

endmodule

// ----- rtl/wildcard_pattern_matcher_unit.sv -----
// Top level of the wildcard pattern matcher: front decoder/queue plus engine.
// Depends on wpm_pkg, wpm_front and wpm_engine.
//
// Case-insensitive '*' / '?' matcher. Items enter through a four-deep command
// queue, so the input side keeps taking items while the engine works or a
// result waits, until that queue is full. The engine handles one command at a
// time and takes none while the result queue is full: clear and append finish
// in the idle state; a subject byte or end of subject with pattern left issues
// the pattern store read, then evaluates its registered data, reading on past
// each star under the pattern pointer until a non-star byte or the pattern end
// (a subject byte after a failure, or with the pattern used up, needs no read).
// The pattern store read and its registered data set the pace of subject bytes.
// Results wait in a two-entry queue and are shown while empty is low.
module wildcard_pattern_matcher_unit import wpm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t item,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  cmd_slot_t head;
  logic      take;

  wpm_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .item (item),
    .full (full),
    .head (head),
    .take (take)
  );

  wpm_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .take   (take),
    .empty  (empty),
    .result (result),
    .pop    (pop)
  );

endmodule

// ----- rtl/wpm_checker.sv -----
// Port-level checker for wildcard_pattern_matcher_unit, with its bind.
// Depends on wpm_pkg.
module wpm_checker import wpm_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     push,
  input in_item_t item,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input result_t  result
);

  logic       end_in;
  logic       res_out;
  logic [3:0] owed;

  assign end_in  = push && !full && (item.opcode == OP_END);
  assign res_out = pop && !empty;

  // count end-of-subject items whose result has not been transferred yet
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      unique case ({end_in, res_out})
        2'b10:   owed <= owed + 1'b1;
        2'b01:   owed <= owed - 1'b1;
        default: owed <= owed;
      endcase
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed or vanished");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (owed != '0))
    else $error("result shown without a pending end of subject");

  a_no_late_end: assert property (@(posedge clk) disable iff (rst)
    (end_in && owed == '0) |=> empty)
    else $error("result shown in the cycle after its end of subject");

endmodule

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (
  .clk    (clk),
  .rst    (rst),
  .push   (push),
  .item   (item),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

// ----- test/testbench.sv -----
// Self-checking testbench for wildcard_pattern_matcher_unit: directed and random
// patterns and subjects, predicted by a scoreboard class and checked per result.
// Depends on wpm_pkg and the matcher RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wpm_pkg::*;

  localparam int unsigned ITEM_TARGET    = 700;
  localparam int unsigned CALM_TAIL      = 100;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 300;
  localparam int unsigned REPORT_CAP     = 100;

  class match_scoreboard;
    logic [7:0]        pattern_mem [PATTERN_DEPTH];
    logic [LEN_W-1:0]  pattern_len;
    logic [LEN_W-1:0]  pattern_ptr;
    logic [ADDR_W-1:0] star_pos;
    bit                star_seen;
    bit                subject_failed;
    bit                overflow;
    result_t           expected_results [$];
    int unsigned       mismatches, items_seen, results_seen;
    int unsigned       matches_seen, overflows_seen, early_fails;

    function new();
      pattern_len    = '0;
      overflow       = 1'b0;
      mismatches     = 0;
      items_seen     = 0;
      results_seen   = 0;
      matches_seen   = 0;
      overflows_seen = 0;
      early_fails    = 0;
      restart_subject();
    endfunction

    function void restart_subject();
      pattern_ptr    = '0;
      star_seen      = 1'b0;
      star_pos       = '0;
      subject_failed = 1'b0;
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
      return c;
    endfunction

    // Advance over stars, remembering the last one as the fallback point.
    function void skip_stars();
      while (pattern_ptr < pattern_len && pattern_mem[pattern_ptr] == CH_STAR) begin
        star_seen   = 1'b1;
        star_pos    = pattern_ptr[ADDR_W-1:0];
        pattern_ptr = pattern_ptr + 1'b1;
      end
    endfunction

    function void note_input(in_item_t it);
      logic [7:0] p;
      bit         hit;
      result_t    r;
      items_seen++;
      case (opcode_t'(it.opcode))
        OP_CLEAR: begin
          pattern_len = '0;
          overflow    = 1'b0;
          restart_subject();
        end
        OP_APPEND: begin
          if (pattern_len < PATTERN_DEPTH) begin
            pattern_mem[pattern_len] = it.char_code;
            pattern_len = pattern_len + 1'b1;
          end else begin
            overflow = 1'b1;
          end
        end
        OP_SUBJECT: begin
          if (!subject_failed) begin
            skip_stars();
            hit = 1'b0;
            if (pattern_ptr < pattern_len) begin
              p   = pattern_mem[pattern_ptr];
              hit = (p == CH_QUESTION) || (to_lower(p) == to_lower(it.char_code));
            end
            if (hit) pattern_ptr = pattern_ptr + 1'b1;
            else if (star_seen) pattern_ptr = {1'b0, star_pos} + 1'b1;
            else subject_failed = 1'b1;
          end
        end
        OP_END: begin
          r.matched = 1'b0;
          if (subject_failed) begin
            early_fails++;
          end else begin
            skip_stars();
            r.matched = (pattern_ptr == pattern_len);
          end
          r.pattern_overflow = overflow;
          expected_results.push_back(r);
          restart_subject();
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result matched=%0b overflow=%0b arrived with none expected",
                         got.matched, got.pattern_overflow));
        return;
      end
      want = expected_results.pop_front();
      results_seen++;
      if (want.matched) matches_seen++;
      if (want.pattern_overflow) overflows_seen++;
      if (got.matched !== want.matched)
        report($sformatf("result %0d matched=%0b, want %0b",
                         results_seen, got.matched, want.matched));
      if (got.pattern_overflow !== want.pattern_overflow)
        report($sformatf("result %0d pattern_overflow=%0b, want %0b",
                         results_seen, got.pattern_overflow, want.pattern_overflow));
    endtask

    task finish_check();
      if (expected_results.size() != 0)
        report($sformatf("%0d results never arrived", expected_results.size()));
    endtask
  endclass

  logic     clk  = 1'b0;
  logic     rst  = 1'b1;
  logic     push = 1'b0;
  in_item_t item = '0;
  logic     full;
  logic     empty;
  logic     pop  = 1'b0;
  result_t  result;

  match_scoreboard sb = new();

  bit          calm          = 1'b0;
  bit          sender_gappy  = 1'b0;
  bit          receiver_busy = 1'b0;
  int unsigned sent          = 0;
  int unsigned quiet_cycles  = 0;
  logic [7:0]  loaded_pattern [$];

  wildcard_pattern_matcher_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #1 clk = ~clk;

  // Sample at the edge: inputs and outputs still hold their pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_input(item);
      if (pop && !empty) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall in bursts during busy windows, never in the calm tail.
  initial begin : result_side
    int unsigned window;
    window = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (window == 0) begin
        receiver_busy = ($urandom_range(0, 2) != 0);
        window        = $urandom_range(50, 400);
      end else begin
        window--;
      end
      if (!calm && receiver_busy && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      pop <= 1'b1;
    end
  end

  function automatic logic [7:0] letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) != 0) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) &&
        $urandom_range(0, 1) != 0)
      return c ^ 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pattern_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 22) return CH_STAR;
    if (r < 35) return CH_QUESTION;
    if (r < 85) return letter();
    // bytes just outside the letter ranges, where folding must not apply
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0: return 8'h40;
        1: return 8'h5B;
        2: return 8'h60;
        default: return 8'h7B;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Hold push high across back-to-back transfers; drop it only for a gap.
  task automatic send_item(opcode_t op, logic [7:0] ch);
    if (!calm && sender_gappy && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    item <= {op, ch};
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    case (op)
      OP_CLEAR:  loaded_pattern.delete();
      OP_APPEND: if (loaded_pattern.size() < PATTERN_DEPTH) loaded_pattern.push_back(ch);
      default: ;
    endcase
  endtask

  task automatic load_pattern(int unsigned len);
    send_item(OP_CLEAR, 8'($urandom));
    repeat (len) send_item(OP_APPEND, pattern_char());
  endtask

  // Build a subject that fits the loaded pattern, optionally damaged once.
  task automatic run_subject(bit corrupt);
    logic [7:0]  subj [$];
    logic [7:0]  c;
    int unsigned pos;
    foreach (loaded_pattern[i]) begin
      c = loaded_pattern[i];
      if (c == CH_STAR) repeat ($urandom_range(0, 3)) subj.push_back(letter());
      else if (c == CH_QUESTION) subj.push_back(8'($urandom_range(0, 255)));
      else subj.push_back(flip_case(c));
    end
    if (corrupt) begin
      pos = $urandom_range(0, subj.size());
      if (subj.size() == 0 || pos == subj.size()) begin
        subj.insert(pos, letter());
      end else begin
        case ($urandom_range(0, 2))
          0: subj.insert(pos, letter());
          1: subj.delete(pos);
          default: subj[pos] = letter();
        endcase
      end
    end
    foreach (subj[i]) send_item(OP_SUBJECT, subj[i]);
    send_item(OP_END, 8'($urandom));
  endtask

  task automatic long_pattern();
    send_item(OP_CLEAR, 8'h00);
    repeat ($urandom_range(60, 70))
      send_item(OP_APPEND, ($urandom_range(0, 7) == 0) ? CH_STAR : letter());
    run_subject($urandom_range(0, 1));
  endtask

  initial begin : stimulus
    int unsigned kind;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pattern, failure latch, zero and top bytes, folding,
    // append during a subject, running off the pattern end.
    sender_gappy = 1'b1;
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_END, 8'h00);
    send_item(OP_SUBJECT, "x");
    send_item(OP_SUBJECT, "y");
    send_item(OP_END, 8'h00);
    send_item(OP_APPEND, CH_STAR);
    send_item(OP_APPEND, "A");
    send_item(OP_APPEND, CH_QUESTION);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, CH_STAR);
    send_item(OP_SUBJECT, "q");
    send_item(OP_SUBJECT, "a");
    send_item(OP_SUBJECT, 8'hFF);
    send_item(OP_SUBJECT, 8'h00);
    send_item(OP_END, 8'h00);
    send_item(OP_SUBJECT, "B");
    send_item(OP_APPEND, "z");
    send_item(OP_SUBJECT, "a");
    send_item(OP_END, 8'h00);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_APPEND, "M");
    send_item(OP_SUBJECT, "m");
    send_item(OP_SUBJECT, "m");
    send_item(OP_END, 8'h00);
    send_item(OP_SUBJECT, "@");
    send_item(OP_END, 8'h00);

    // Fill the store to around its depth, often past it.
    long_pattern();

    while (sent < ITEM_TARGET) begin
      if (sent >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
      sender_gappy = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        load_pattern($urandom_range(0, 8));
        repeat ($urandom_range(1, 3)) run_subject($urandom_range(0, 9) < 3);
      end else if (kind < 70) begin
        run_subject($urandom_range(0, 9) < 3);
      end else if (kind < 80) begin
        load_pattern($urandom_range(0, 5));
        repeat ($urandom_range(0, 3)) send_item(OP_SUBJECT, letter());
        repeat ($urandom_range(1, 3)) send_item(OP_APPEND, pattern_char());
        run_subject($urandom_range(0, 9) < 3);
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 8))
          send_item(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        long_pattern();
      end else begin
        case ($urandom_range(0, 2))
          0: send_item(OP_END, 8'($urandom));
          1: begin
            send_item(OP_CLEAR, 8'($urandom));
            repeat ($urandom_range(1, 4)) send_item(OP_SUBJECT, letter());
            send_item(OP_END, 8'($urandom));
          end
          default: begin
            repeat ($urandom_range(1, 5)) send_item(OP_SUBJECT, 8'($urandom_range(0, 255)));
            send_item(OP_END, 8'($urandom));
          end
        endcase
      end
    end
    send_item(OP_END, 8'h00);
    push <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();

    $display("covered %0d items and %0d finished subjects: %0d matches, %0d with dropped bytes",
             sb.items_seen, sb.results_seen, sb.matches_seen, sb.overflows_seen);
    $display("%0d subjects failed before their end; %0d mismatches",
             sb.early_fails, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
